// ===== rtl/btans_pkg.sv =====
// Shared constants and types for the binary tANS encoder.
package btans_pkg;

  // Fixed widths of the coder state and of the zero-range register
  localparam int unsigned STATE_W         = 13;
  localparam int unsigned RANGE_W         = 12;
  localparam int unsigned OCTAVE_BITS_DEF = 9;

  localparam logic [RANGE_W-1:0] ZERO_RANGE_RESET = 12'd358;

  // Item kind codes
  localparam logic KIND_ENCODE = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  // Encoder control sequence
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT,
    ST_DIV
  } enc_state_t;

endpackage

// ===== rtl/btans_state_mem.sv =====
// Single-entry coder state memory with registered read and reset-valid bit.
module btans_state_mem #(
  parameter int unsigned OCTAVE_BITS = btans_pkg::OCTAVE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic                          wr_en,
  input  logic [btans_pkg::STATE_W-1:0] wr_data,
  output logic [btans_pkg::STATE_W-1:0] rd_data
);
  import btans_pkg::*;

  localparam logic [STATE_W-1:0] OCTAVE_LEN = STATE_W'(1) << OCTAVE_BITS;

  logic [STATE_W-1:0] mem_r [1];
  logic               valid_r;
  logic [STATE_W-1:0] rd_data_r;

  // Valid bit: an unwritten entry reads as the reset state L
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_en) begin
      valid_r <= 1'b1;
    end
  end

  // Storage write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[0] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= valid_r ? mem_r[0] : OCTAVE_LEN;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/btans_div.sv =====
// Restoring divider, one quotient bit per cycle, for the state transition.
module btans_div #(
  parameter int unsigned OCTAVE_BITS = btans_pkg::OCTAVE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [2*OCTAVE_BITS+1:0]   num,
  input  logic [OCTAVE_BITS-1:0]     den,
  output logic                       done,
  output logic [OCTAVE_BITS+1:0]     quot,
  output logic                       rem_zero
);
  import btans_pkg::*;

  // Quotient is at most 2L, so OCTAVE_BITS+2 bits suffice
  localparam int unsigned QW = OCTAVE_BITS + 2;
  localparam int unsigned NW = 2 * OCTAVE_BITS + 2;
  localparam int unsigned CW = $clog2(QW + 1);

  logic                   busy_r;
  logic                   done_r;
  logic [CW-1:0]          cnt_r;
  logic [OCTAVE_BITS-1:0] rem_r;
  logic [OCTAVE_BITS-1:0] den_r;
  logic [QW-1:0]          acc_r;

  logic [OCTAVE_BITS:0]   shifted;
  logic [OCTAVE_BITS+1:0] trial;
  logic                   q_bit;

  // Trial subtract of the divisor from the shifted partial remainder
  assign shifted = {rem_r, acc_r[QW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_r};
  assign q_bit   = ~trial[OCTAVE_BITS+1];

  // Control: busy until every quotient bit is produced, done pulses once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: numerator low bits shift out, quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[NW-1:QW];
      acc_r <= num[QW-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= q_bit ? trial[OCTAVE_BITS-1:0] : shifted[OCTAVE_BITS-1:0];
      acc_r <= {acc_r[QW-2:0], q_bit};
    end
  end

  assign done     = done_r;
  assign quot     = acc_r;
  assign rem_zero = (rem_r == '0);

endmodule

// ===== rtl/binary_tans_encoder_core.sv =====
// Top level of the binary tANS encoder: sequencer, renormalization and output register.
//
// Binary tabled ANS encoder. The coder state lives in a single-entry memory
// and starts at L = 2^OCTAVE_BITS. Each encode item emits k low state bits
// (LSB first, one per cycle while the output is not stalled) and then runs
// the state transition through a restoring divider that produces one
// quotient bit per cycle. A flush emits all remaining state bits. Output
// stalls hold the emission while bits are pending. The input is taken
// again as soon as the state is written back, even while the final bit
// still waits in the output register. zero_range may be written only while
// no item is in flight.
module binary_tans_encoder_core #(
  parameter int unsigned OCTAVE_BITS = btans_pkg::OCTAVE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [btans_pkg::RANGE_W-1:0] cfg_zero_range,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic                          in_symbol_bit,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_code_bit,
  output logic                          out_last
);
  import btans_pkg::*;

  localparam int unsigned OB     = OCTAVE_BITS;
  localparam int unsigned QW     = OB + 2;
  localparam int unsigned NW     = 2 * OB + 2;
  localparam int unsigned NEXT_W = (QW + 1 > STATE_W) ? QW + 1 : STATE_W;

  localparam logic [STATE_W-1:0] OCTAVE_LEN = STATE_W'(1) << OB;
  localparam logic [OB-1:0]      RANGE_MAX  = OB'((1 << OB) - 1);
  localparam logic [OB-1:0]      HALF_LEN   = OB'(1 << (OB - 1));

  enc_state_t state_r, state_nxt;

  logic [RANGE_W-1:0] zero_range_r;
  logic               kind_r, kind_nxt;
  logic               lps_r, lps_nxt;
  logic [OB-1:0]      r_r, r_nxt;
  logic [STATE_W-1:0] x_r, x_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_code_bit_r, out_code_bit_nxt;
  logic               out_last_r, out_last_nxt;

  logic               mem_rd_en;
  logic               mem_wr_en;
  logic [STATE_W-1:0] mem_wr_data;
  logic [STATE_W-1:0] mem_rd_data;

  logic               div_start;
  logic               div_done;
  logic [NW-1:0]      div_num;
  logic [QW-1:0]      div_quot;
  logic               div_rem_zero;

  logic [STATE_W-1:0] zr_ext;
  logic [OB-1:0]      r0;
  logic [OB-1:0]      r1;
  logic               mps;
  logic [STATE_W-1:0] lim;
  logic [STATE_W-1:0] x_sh;
  logic               cont;
  logic               cont_sh;
  logic               slot_free;
  logic               accept;
  logic [OB:0]        x_lo;
  logic [OB:0]        x_p1;
  logic [NW-1:0]      num_mps;
  logic [NW-1:0]      num_lps;
  logic [NEXT_W-1:0]  next_mps;
  logic [NEXT_W-1:0]  next_lps;

  // Clamp the zero range to 1..L-1 and derive the one range
  assign zr_ext = STATE_W'(zero_range_r);
  always_comb begin
    if (zr_ext == '0) begin
      r0 = OB'(1);
    end else if (zr_ext >= OCTAVE_LEN) begin
      r0 = RANGE_MAX;
    end else begin
      r0 = zr_ext[OB-1:0];
    end
  end
  assign r1  = OB'(OCTAVE_LEN) - r0;
  assign mps = (r0 > HALF_LEN) ? 1'b0 : 1'b1;

  // Renormalization limits: encode shifts while x > 2r-1, flush while x != 0
  assign lim     = STATE_W'({r_r, 1'b0}) - STATE_W'(1);
  assign x_sh    = x_r >> 1;
  assign cont    = (kind_r == KIND_FLUSH) ? (x_r != '0) : (x_r > lim);
  assign cont_sh = (kind_r == KIND_FLUSH) ? (x_sh != '0) : (x_sh > lim);

  // Transition numerators: (x+1)L + r-1 for the likely symbol, xL otherwise
  assign x_lo    = x_r[OB:0];
  assign x_p1    = x_lo + (OB + 1)'(1);
  assign num_mps = NW'({x_p1, {OB{1'b0}}}) + NW'(r_r) - NW'(1);
  assign num_lps = NW'({x_lo, {OB{1'b0}}});
  assign div_num = lps_r ? num_lps : num_mps;

  assign next_mps = NEXT_W'(div_quot) - NEXT_W'(1);
  assign next_lps = NEXT_W'(div_quot) + NEXT_W'(div_rem_zero);

  assign slot_free = ~out_valid_r | ~out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid & ~in_stall;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_range_r <= ZERO_RANGE_RESET;
    end else if (cfg_we) begin
      zero_range_r <= cfg_zero_range;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind_r         <= kind_nxt;
    lps_r          <= lps_nxt;
    r_r            <= r_nxt;
    x_r            <= x_nxt;
    out_code_bit_r <= out_code_bit_nxt;
    out_last_r     <= out_last_nxt;
  end

  // Sequencer: read state, emit bits, divide (encode only), write back
  always_comb begin
    state_nxt        = state_r;
    kind_nxt         = kind_r;
    lps_nxt          = lps_r;
    r_nxt            = r_r;
    x_nxt            = x_r;
    out_valid_nxt    = out_valid_r & out_stall;
    out_code_bit_nxt = out_code_bit_r;
    out_last_nxt     = out_last_r;
    mem_rd_en        = 1'b0;
    mem_wr_en        = 1'b0;
    mem_wr_data      = OCTAVE_LEN;
    div_start        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          kind_nxt  = in_kind;
          lps_nxt   = (in_symbol_bit != mps);
          r_nxt     = in_symbol_bit ? r1 : r0;
          mem_rd_en = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        x_nxt     = mem_rd_data;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (cont) begin
          if (slot_free) begin
            out_valid_nxt    = 1'b1;
            out_code_bit_nxt = x_r[0];
            out_last_nxt     = ~cont_sh;
            x_nxt            = x_sh;
          end
        end else if (kind_r == KIND_FLUSH) begin
          mem_wr_en   = 1'b1;
          mem_wr_data = OCTAVE_LEN;
          state_nxt   = ST_IDLE;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          mem_wr_en   = 1'b1;
          mem_wr_data = lps_r ? next_lps[STATE_W-1:0] : next_mps[STATE_W-1:0];
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  btans_state_mem #(
    .OCTAVE_BITS (OCTAVE_BITS)
  ) u_state_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd_en),
    .wr_en   (mem_wr_en),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

  btans_div #(
    .OCTAVE_BITS (OCTAVE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      (div_num),
    .den      (r_r),
    .done     (div_done),
    .quot     (div_quot),
    .rem_zero (div_rem_zero)
  );

  assign out_valid    = out_valid_r;
  assign out_code_bit = out_code_bit_r;
  assign out_last     = out_last_r;

endmodule

// ===== dv/btans_code_checker.sv =====
// Checker for the binary tANS encoder: predicts the code bit stream and compares transfers.
module btans_code_checker #(
  parameter int unsigned OCTAVE_BITS = btans_pkg::OCTAVE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [btans_pkg::RANGE_W-1:0] cfg_zero_range,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_kind,
  input  logic                          in_symbol_bit,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_code_bit,
  input  logic                          out_last,
  output int                            fail_count,
  output int                            pending_bits
);
  import btans_pkg::*;

  localparam int unsigned OCT_LEN  = 1 << OCTAVE_BITS;
  localparam int unsigned MAX_BITS = STATE_W;

  typedef struct packed {
    logic code_bit;
    logic last;
  } code_beat_t;

  // Expected code bits, oldest first
  code_beat_t         expected_bits[$];
  logic [STATE_W-1:0] coder_state;
  logic [RANGE_W-1:0] zero_range;
  int                 errors = 0;

  // Effective r0: 0 acts as 1, L and above act as L-1
  function automatic int unsigned eff_zero_range(logic [RANGE_W-1:0] raw);
    int unsigned r;
    r = 32'(raw);
    if (r < 1) r = 1;
    if (r > OCT_LEN - 1) r = OCT_LEN - 1;
    return r;
  endfunction

  // Renormalize, queue the emitted bits and advance the coder state
  task automatic encode_item(logic kind, logic sym);
    logic [31:0] orig;
    int unsigned x, r0, r, num, nxt;
    int          n;
    logic        mps;
    code_beat_t  beat;
    orig = 32'(coder_state);
    x    = 32'(coder_state);
    n    = 0;
    if (kind == KIND_FLUSH) begin
      while (x > 0 && n < MAX_BITS) begin
        x = x >> 1;
        n++;
      end
      nxt = OCT_LEN;
    end else begin
      r0  = eff_zero_range(zero_range);
      r   = (sym == 1'b0) ? r0 : OCT_LEN - r0;
      mps = (2 * r0 > OCT_LEN) ? 1'b0 : 1'b1;
      while (x > 2 * r - 1 && n < MAX_BITS) begin
        x = x >> 1;
        n++;
      end
      if (sym == mps) begin
        // more probable symbol: ceil((x+1)L/r) - 1
        num = (x + 1) * OCT_LEN;
        nxt = (num + r - 1) / r - 1;
      end else begin
        // less probable symbol: floor(xL/r), bumped when exact
        num = x * OCT_LEN;
        nxt = num / r;
        if (num % r == 0) nxt++;
      end
    end
    // emitted bits are simply the low n bits of the old state, LSB first
    for (int i = 0; i < n; i++) begin
      beat.code_bit = orig[i];
      beat.last     = (i == n - 1);
      expected_bits.insert(expected_bits.size(), beat);
    end
    coder_state = nxt[STATE_W-1:0];
  endtask

  always @(posedge clk) begin : watch
    code_beat_t want;
    if (!rst_n) begin
      coder_state = STATE_W'(OCT_LEN);
      zero_range  = ZERO_RANGE_RESET;
      expected_bits.delete();
    end else begin
      if (cfg_we) zero_range = cfg_zero_range;
      // input transfer
      if (in_valid && !in_stall) encode_item(in_kind, in_symbol_bit);
      // output transfer
      if (out_valid && !out_stall) begin
        if (expected_bits.size() == 0) begin
          $error("unexpected code bit %0d (last %0d)", out_code_bit, out_last);
          errors++;
        end else begin
          want = expected_bits.pop_front();
          if (out_code_bit !== want.code_bit) begin
            $error("code_bit mismatch: expected %0d, got %0d", want.code_bit, out_code_bit);
            errors++;
          end
          if (out_last !== want.last) begin
            $error("last mismatch: expected %0d, got %0d", want.last, out_last);
            errors++;
          end
        end
      end
    end
    fail_count   <= errors;
    pending_bits <= expected_bits.size();
  end

endmodule

// ===== dv/tb_binary_tans_encoder_core.sv =====
// Testbench top for the binary tANS encoder: stimulus, stall patterns and verdict.
module tb_binary_tans_encoder_core;
  import btans_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  // an encode that emits nothing still holds the input while the divider runs
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS   = 57;
  localparam int unsigned NUM_PHASES    = 8;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               cfg_we         = 1'b0;
  logic [RANGE_W-1:0] cfg_zero_range = '0;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic               in_kind        = KIND_ENCODE;
  logic               in_symbol_bit  = 1'b0;
  logic               out_valid;
  logic               out_stall      = 1'b0;
  logic               out_code_bit;
  logic               out_last;
  int                 fail_count;
  int                 pending_bits;

  int unsigned        cycles     = 0;
  int                 burst_left = 0;
  bit                 no_gaps    = 1'b0;

  always #2 clk = ~clk;

  binary_tans_encoder_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_zero_range(cfg_zero_range),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_symbol_bit (in_symbol_bit),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_code_bit  (out_code_bit),
    .out_last      (out_last)
  );

  btans_code_checker code_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_zero_range(cfg_zero_range),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_symbol_bit (in_symbol_bit),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_code_bit  (out_code_bit),
    .out_last      (out_last),
    .fail_count    (fail_count),
    .pending_bits  (pending_bits)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_binary_tans_encoder_core failed");
      $finish;
    end
  end

  // Receiver back-pressure: a randomly redrawn mode sets how often the output stalls
  int unsigned stall_mode = 0;
  always @(posedge clk) begin
    if (cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      2: begin
        out_stall <= 1'($urandom_range(0, 1));
      end
      default: begin
        out_stall <= ($urandom_range(0, 7) != 0);
      end
    endcase
  end

  // One input transfer, with bursts and random gaps in front
  task automatic send_item(logic kind, logic sym);
    int gap;
    if (burst_left == 0) begin
      if (no_gaps) gap = 0;
      else if ($urandom_range(0, 3) == 0) gap = $urandom_range(7, 24);
      else gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_symbol_bit <= sym;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  // Wait until every expected bit is out and the divider is done
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_bits != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_zero_range(logic [RANGE_W-1:0] value);
    settle();
    cfg_we         <= 1'b1;
    cfg_zero_range <= value;
    @(posedge clk);
    cfg_we         <= 1'b0;
  endtask

  initial begin : stimulus
    logic [RANGE_W-1:0] phase_range [NUM_PHASES];
    int unsigned        one_share;
    int unsigned        flush_share;
    logic               kind;
    phase_range = '{12'd1, 12'd511, 12'd4095, 12'd0, 12'd256, 12'd257, 12'd0, 12'd0};
    phase_range[6] = RANGE_W'($urandom_range(0, 4095));
    phase_range[7] = RANGE_W'($urandom_range(1, 511));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset range, nothing to emit, emits, flush from L
    send_item(KIND_ENCODE, 1'b0);
    send_item(KIND_ENCODE, 1'b1);
    send_item(KIND_ENCODE, 1'b0);
    send_item(KIND_FLUSH, 1'b0);
    send_item(KIND_FLUSH, 1'b1);
    send_item(KIND_ENCODE, 1'b1);
    // range 0 acts as 1: symbol zero drains nine bits
    write_zero_range(12'd0);
    send_item(KIND_ENCODE, 1'b0);
    send_item(KIND_ENCODE, 1'b0);
    send_item(KIND_ENCODE, 1'b1);
    send_item(KIND_FLUSH, 1'b0);
    // all-ones range clamps to L-1: symbol one gets range 1
    write_zero_range(12'd4095);
    send_item(KIND_ENCODE, 1'b1);
    send_item(KIND_ENCODE, 1'b0);
    send_item(KIND_FLUSH, 1'b1);
    // even split: symbol one counts as the more probable one
    write_zero_range(12'd256);
    send_item(KIND_ENCODE, 1'b0);
    send_item(KIND_ENCODE, 1'b1);
    send_item(KIND_ENCODE, 1'b1);
    send_item(KIND_FLUSH, 1'b0);

    // Random phases, each with its own range, symbol skew and flush rate
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_zero_range(phase_range[p]);
      one_share   = $urandom_range(0, 100);
      flush_share = $urandom_range(2, 20);
      no_gaps     = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        kind = ($urandom_range(0, 99) < flush_share) ? KIND_FLUSH : KIND_ENCODE;
        send_item(kind, $urandom_range(0, 99) < one_share);
      end
      no_gaps = 1'b0;
    end

    settle();
    if (fail_count == 0 && pending_bits == 0) begin
      $display("tb_binary_tans_encoder_core passed");
    end else begin
      $display("tb_binary_tans_encoder_core failed");
    end
    $finish;
  end

endmodule
